// File: hw/rtl/rcnh_pkg.sv
// Shared constants, types and helpers for the ray and circle nearest-hit block.
package rcnh_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W = 32;
  // A unit-vector component lies in [-2^FRAC_BITS, 2^FRAC_BITS].
  localparam int UNIT_W = FRAC_BITS + 2;
  localparam int MUL_W = 35;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIV_W = WORD_W + FRAC_BITS;
  localparam int SQ_W = 2 * WORD_W;
  localparam int IN_DATA_W = 8 * WORD_W;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_L_SQX,
    ST_L_SQY,
    ST_L_ROOT,
    ST_L_NW,
    ST_L_DXW,
    ST_L_DYW,
    ST_C_DOT1,
    ST_C_DOT2,
    ST_C_CR1,
    ST_C_CR2,
    ST_C_CHK,
    ST_C_RR,
    ST_C_ROOT,
    ST_C_SW,
    ST_C_HX,
    ST_C_HY,
    ST_C_UPD,
    ST_FIN
  } state_t;

  // Saturate a 36-bit signed sum to the signed 32-bit range.
  function automatic logic [WORD_W-1:0] sat_word(input logic signed [WORD_W+3:0] v);
    logic signed [WORD_W+3:0] hi;
    logic signed [WORD_W+3:0] lo;
    hi = (WORD_W+4)'(36'sh07FFFFFFF);
    lo = -(WORD_W+4)'(36'sh080000000);
    if (v > hi) begin
      return 32'h7FFFFFFF;
    end else if (v < lo) begin
      return 32'h80000000;
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/rcnh_mul.sv
// Shared signed multiplier with a registered product.
module rcnh_mul (
  input  logic                                clk,
  input  logic signed [rcnh_pkg::MUL_W-1:0]  a,
  input  logic signed [rcnh_pkg::MUL_W-1:0]  b,
  output logic signed [rcnh_pkg::PROD_W-1:0] p
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: hw/rtl/rcnh_sqrt.sv
// Iterative floor integer square root, two radicand bits per cycle.
module rcnh_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rcnh_pkg::SQ_W-1:0]         value,
  output logic                              busy,
  output logic [rcnh_pkg::WORD_W-1:0]       root
);

  logic [rcnh_pkg::SQ_W-1:0] v;
  logic [rcnh_pkg::SQ_W-1:0] r;
  logic [rcnh_pkg::SQ_W-1:0] bitv;
  logic [rcnh_pkg::SQ_W-1:0] trial;

  assign trial = r + bitv;
  assign root = r[rcnh_pkg::WORD_W-1:0];

  // Control: busy until the lowest bit position has been tried.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bitv == rcnh_pkg::SQ_W'(1)) begin
      busy <= 1'b0;
    end
  end

  // Datapath: one restoring step per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      v <= value;
      r <= '0;
      bitv <= rcnh_pkg::SQ_W'(1) << (rcnh_pkg::SQ_W - 2);
    end else if (busy) begin
      if (v >= trial) begin
        v <= v - trial;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// File: hw/rtl/rcnh_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
module rcnh_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rcnh_pkg::DIV_W-1:0]        dividend,
  input  logic [rcnh_pkg::WORD_W-1:0]       divisor,
  output logic                              busy,
  output logic [rcnh_pkg::DIV_W-1:0]        quotient
);

  localparam int CNT_W = $clog2(rcnh_pkg::DIV_W + 1);

  logic [rcnh_pkg::WORD_W-1:0] rem;
  logic [rcnh_pkg::WORD_W-1:0] den;
  logic [CNT_W-1:0]            cnt;
  logic [rcnh_pkg::WORD_W:0]   shifted;
  logic                        take;

  assign shifted = {rem, quotient[rcnh_pkg::DIV_W-1]};
  assign take = shifted >= {1'b0, den};

  // Control: count the quotient bits still to produce.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNT_W'(rcnh_pkg::DIV_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: shift in a dividend bit, subtract when the divisor fits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (take) begin
        rem <= rcnh_pkg::WORD_W'(shifted - {1'b0, den});
      end else begin
        rem <= shifted[rcnh_pkg::WORD_W-1:0];
      end
      quotient <= {quotient[rcnh_pkg::DIV_W-2:0], take};
    end
  end

endmodule

// File: hw/rtl/ray_circle_nearest_hit.sv
// Top level: casts a ray against a stream of circles and keeps the nearest hit.
//
// Input channel s_*: each item either loads a ray (s_tuser op bit 0) or presents
// one circle (op bit 1, present in tuser bit 1). s_tlast marks the item after
// which the best distance, hit point and hit flag are sent on the m_* channel.
// The cfg_* channel writes the signed radius bonus; it is always ready.
// One item is worked on at a time by a sequencer around one shared multiplier,
// one iterative square root (one step per cycle, 32 steps) and one iterative
// divider (48 steps). A circle runs the products and geometry checks, then,
// if it passes, the square root and, if nearer, the hit-point update; an
// absent circle goes straight to the finish. Loading a ray runs the square
// root and the two unit-vector divisions, which a zero direction skips.
// The result waits in an output register, so the next item is accepted while
// it is stalled; only a second result waits for the first to be taken.
// Reset clears the ray, sets the best distance to all ones, clears the bonus
// and drops m_tvalid.
module ray_circle_nearest_hit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // start_x, start_y, dir_x, dir_y, initial_hit, center_x, center_y, radius
  input  logic [rcnh_pkg::IN_DATA_W-1:0]        s_tdata,
  // op, present
  input  logic [1:0]                            s_tuser,
  input  logic                                  s_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // hit_distance, hit_x, hit_y, circle_hit, zero fill
  output logic [rcnh_pkg::OUT_DATA_W-1:0]       m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rcnh_pkg::WORD_W-1:0]           cfg_data
);

  localparam int W = rcnh_pkg::WORD_W;
  localparam int F = rcnh_pkg::FRAC_BITS;
  localparam int UW = rcnh_pkg::UNIT_W;
  localparam int MW = rcnh_pkg::MUL_W;

  rcnh_pkg::state_t state, state_next;

  logic signed [W-1:0]    radius_bonus;
  logic signed [W-1:0]    origin_x, origin_y;
  logic signed [UW-1:0]   unit_dir_x, unit_dir_y;
  logic [W-1:0]           best_distance;
  logic [W-1:0]           best_x, best_y;
  logic                   hit_flag;

  logic                   it_last;
  logic signed [W-1:0]    dxr, dyr;
  logic signed [W:0]      tx, ty;
  logic signed [W+1:0]    reff;
  logic signed [63:0]     acc1, acc2;
  logic signed [MW-1:0]   tval, sval;
  logic [W-1:0]           rm;
  logic [W:0]             rp;
  logic [W+1:0]           near_dist;
  logic [W-1:0]           hx;

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [rcnh_pkg::PROD_W-1:0] prod;
  logic                   sq_start, sq_busy;
  logic [rcnh_pkg::SQ_W-1:0] sq_val;
  logic [W-1:0]           sq_root;
  logic                   dv_start, dv_busy;
  logic [rcnh_pkg::DIV_W-1:0] dv_num, dv_quo;
  logic                   out_load;

  logic                   accept;
  logic signed [W-1:0]    in_sx, in_sy, in_dx, in_dy, in_cx, in_cy;
  logic [W-1:0]           in_init, in_rad;
  logic [W-1:0]           abs_dx, abs_dy;
  logic signed [63:0]     cross_val;
  logic [63:0]            cross_abs;
  logic [W+1:0]           dval;
  logic [W-1:0]           rsat;
  logic signed [MW-1:0]   s_calc;
  logic [W+1:0]           dist_calc;
  logic signed [MW-1:0]   hit_off;
  logic [UW-1:0]          q_unit;

  assign in_sx = s_tdata[W-1:0];
  assign in_sy = s_tdata[2*W-1:W];
  assign in_dx = s_tdata[3*W-1:2*W];
  assign in_dy = s_tdata[4*W-1:3*W];
  assign in_init = s_tdata[5*W-1:4*W];
  assign in_cx = s_tdata[6*W-1:5*W];
  assign in_cy = s_tdata[7*W-1:6*W];
  assign in_rad = s_tdata[8*W-1:7*W];

  assign s_tready = (state == rcnh_pkg::ST_IDLE);
  assign accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Magnitudes of the stored direction for the normalizing divisions.
  assign abs_dx = dxr[W-1] ? W'(-dxr) : dxr;
  assign abs_dy = dyr[W-1] ? W'(-dyr) : dyr;
  assign q_unit = dv_quo[UW-1:0];

  // Circle geometry terms.
  assign cross_val = acc2 - 64'(prod);
  assign cross_abs = cross_val[63] ? 64'(-cross_val) : cross_val;
  assign dval = cross_abs[F+W+1:F];
  assign rsat = (reff > $signed({2'b00, {W{1'b1}}})) ? {W{1'b1}} : reff[W-1:0];
  assign s_calc = tval - $signed({3'b000, sq_root});
  assign dist_calc = s_calc[MW-1] ? (W+2)'(-s_calc) : (W+2)'(s_calc);
  assign hit_off = prod[F+MW-1:F];

  rcnh_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (prod)
  );

  rcnh_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .value(sq_val),
    .busy (sq_busy),
    .root (sq_root)
  );

  rcnh_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (dv_start),
    .dividend(dv_num),
    .divisor (sq_root),
    .busy    (dv_busy),
    .quotient(dv_quo)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcnh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and the operands of the shared units.
  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    sq_start = 1'b0;
    sq_val = 64'(acc1) + 64'(prod);
    dv_start = 1'b0;
    dv_num = {abs_dx, {F{1'b0}}};
    out_load = 1'b0;
    unique case (state)
      rcnh_pkg::ST_IDLE: begin
        if (accept) begin
          if (!s_tuser[0]) begin
            state_next = rcnh_pkg::ST_L_SQX;
          end else if (s_tuser[1] && (unit_dir_x != '0 || unit_dir_y != '0)) begin
            state_next = rcnh_pkg::ST_C_DOT1;
          end else begin
            state_next = rcnh_pkg::ST_FIN;
          end
        end
      end
      rcnh_pkg::ST_L_SQX: begin
        mul_a = MW'(dxr);
        mul_b = MW'(dxr);
        state_next = rcnh_pkg::ST_L_SQY;
      end
      rcnh_pkg::ST_L_SQY: begin
        mul_a = MW'(dyr);
        mul_b = MW'(dyr);
        state_next = rcnh_pkg::ST_L_ROOT;
      end
      rcnh_pkg::ST_L_ROOT: begin
        sq_start = 1'b1;
        state_next = rcnh_pkg::ST_L_NW;
      end
      rcnh_pkg::ST_L_NW: begin
        if (!sq_busy) begin
          if (sq_root == '0) begin
            state_next = rcnh_pkg::ST_FIN;
          end else begin
            dv_start = 1'b1;
            state_next = rcnh_pkg::ST_L_DXW;
          end
        end
      end
      rcnh_pkg::ST_L_DXW: begin
        dv_num = {abs_dy, {F{1'b0}}};
        if (!dv_busy) begin
          dv_start = 1'b1;
          state_next = rcnh_pkg::ST_L_DYW;
        end
      end
      rcnh_pkg::ST_L_DYW: begin
        if (!dv_busy) begin
          state_next = rcnh_pkg::ST_FIN;
        end
      end
      rcnh_pkg::ST_C_DOT1: begin
        mul_a = MW'(tx);
        mul_b = MW'(unit_dir_x);
        state_next = rcnh_pkg::ST_C_DOT2;
      end
      rcnh_pkg::ST_C_DOT2: begin
        mul_a = MW'(ty);
        mul_b = MW'(unit_dir_y);
        state_next = rcnh_pkg::ST_C_CR1;
      end
      rcnh_pkg::ST_C_CR1: begin
        mul_a = MW'(tx);
        mul_b = MW'(unit_dir_y);
        state_next = rcnh_pkg::ST_C_CR2;
      end
      rcnh_pkg::ST_C_CR2: begin
        mul_a = MW'(ty);
        mul_b = MW'(unit_dir_x);
        state_next = rcnh_pkg::ST_C_CHK;
      end
      rcnh_pkg::ST_C_CHK: begin
        if (acc1[63] || reff[W+1] || dval > {2'b00, rsat}) begin
          state_next = rcnh_pkg::ST_FIN;
        end else begin
          state_next = rcnh_pkg::ST_C_RR;
        end
      end
      rcnh_pkg::ST_C_RR: begin
        mul_a = $signed({3'b000, rm});
        mul_b = $signed({2'b00, rp});
        state_next = rcnh_pkg::ST_C_ROOT;
      end
      rcnh_pkg::ST_C_ROOT: begin
        sq_start = 1'b1;
        sq_val = prod[rcnh_pkg::SQ_W-1:0];
        state_next = rcnh_pkg::ST_C_SW;
      end
      rcnh_pkg::ST_C_SW: begin
        if (!sq_busy) begin
          if (dist_calc < {2'b00, best_distance}) begin
            state_next = rcnh_pkg::ST_C_HX;
          end else begin
            state_next = rcnh_pkg::ST_FIN;
          end
        end
      end
      rcnh_pkg::ST_C_HX: begin
        mul_a = MW'(unit_dir_x);
        mul_b = sval;
        state_next = rcnh_pkg::ST_C_HY;
      end
      rcnh_pkg::ST_C_HY: begin
        mul_a = MW'(unit_dir_y);
        mul_b = sval;
        state_next = rcnh_pkg::ST_C_UPD;
      end
      rcnh_pkg::ST_C_UPD: begin
        state_next = rcnh_pkg::ST_FIN;
      end
      rcnh_pkg::ST_FIN: begin
        if (!it_last) begin
          state_next = rcnh_pkg::ST_IDLE;
        end else if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          state_next = rcnh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rcnh_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_bonus <= '0;
    end else if (cfg_valid && cfg_ready) begin
      radius_bonus <= cfg_data;
    end
  end

  // Ray and best-hit state.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      unit_dir_x <= '0;
      unit_dir_y <= '0;
      best_distance <= '1;
      best_x <= '0;
      best_y <= '0;
      hit_flag <= 1'b0;
    end else begin
      if (accept && !s_tuser[0]) begin
        origin_x <= in_sx;
        origin_y <= in_sy;
        best_distance <= in_init;
        best_x <= '0;
        best_y <= '0;
        hit_flag <= 1'b0;
      end
      if (state == rcnh_pkg::ST_L_NW && !sq_busy && sq_root == '0) begin
        unit_dir_x <= '0;
        unit_dir_y <= '0;
      end
      if (state == rcnh_pkg::ST_L_DXW && !dv_busy) begin
        unit_dir_x <= dxr[W-1] ? UW'(-q_unit) : q_unit;
      end
      if (state == rcnh_pkg::ST_L_DYW && !dv_busy) begin
        unit_dir_y <= dyr[W-1] ? UW'(-q_unit) : q_unit;
      end
      if (state == rcnh_pkg::ST_C_UPD) begin
        best_distance <= near_dist[W-1:0];
        best_x <= hx;
        best_y <= rcnh_pkg::sat_word((W+4)'(origin_y) + (W+4)'(hit_off));
        hit_flag <= 1'b1;
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    if (accept) begin
      it_last <= s_tlast;
      dxr <= in_dx;
      dyr <= in_dy;
      tx <= (W+1)'(in_cx) - (W+1)'(origin_x);
      ty <= (W+1)'(in_cy) - (W+1)'(origin_y);
      reff <= $signed({2'b00, in_rad}) + (W+2)'(radius_bonus);
    end
    unique case (state)
      rcnh_pkg::ST_L_SQY, rcnh_pkg::ST_C_DOT2: acc1 <= 64'(prod);
      rcnh_pkg::ST_C_CR1: acc1 <= acc1 + 64'(prod);
      rcnh_pkg::ST_C_CR2: acc2 <= 64'(prod);
      rcnh_pkg::ST_C_CHK: begin
        tval <= acc1[F+MW-1:F];
        rm <= rsat - dval[W-1:0];
        rp <= {1'b0, rsat} + {1'b0, dval[W-1:0]};
      end
      rcnh_pkg::ST_C_SW: begin
        sval <= s_calc;
        near_dist <= dist_calc;
      end
      rcnh_pkg::ST_C_HY: hx <= rcnh_pkg::sat_word((W+4)'(origin_x) + (W+4)'(hit_off));
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'b0, hit_flag, best_y, best_x, best_distance};
    end
  end

endmodule
